// ===== hw/rtl/sv39w_pkg.sv =====
// shared types and constants of the sv39 page table map walker
package sv39w_pkg;

	localparam int PPN_W    = 44;
	localparam int VA_W     = 39;
	localparam int FLAGS_W  = 10;
	localparam int ENTRY_W  = 64;
	localparam int STATUS_W = 2;
	localparam int VPN_W    = 9;
	localparam int PAGE_SHIFT = 12;
	localparam int PPN_SHIFT  = 10;

	// action codes
	localparam logic [1:0] ACT_MAP    = 2'd0;
	localparam logic [1:0] ACT_LOOKUP = 2'd1;
	localparam logic [1:0] ACT_ALLOC  = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OUT  = 2'd2;

	// result selection codes
	localparam logic [2:0] RES_ZERO  = 3'd0;
	localparam logic [2:0] RES_MAP   = 3'd1;
	localparam logic [2:0] RES_LOOK  = 3'd2;
	localparam logic [2:0] RES_ALLOC = 3'd3;
	localparam logic [2:0] RES_FULL  = 3'd4;
	localparam logic [2:0] RES_OUT   = 3'd5;

	// controller to datapath commands
	typedef struct packed {
		logic       load;
		logic       rd;
		logic       clr_wr;
		logic       link_wr;
		logic       leaf_wr;
		logic       ptr_from_rd;
		logic       cur_from_ptr;
		logic       lvl_dec;
		logic       bump;
		logic       res_set;
		logic [2:0] res_sel;
		logic       out_load;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [1:0] action;
		logic       ptr_ok;
		logic       rd_valid;
		logic       full;
		logic       level_zero;
		logic       level_one;
		logic       clr_done;
	} sts_t;

endpackage

// ===== hw/rtl/sv39w_datapath.sv =====
// datapath of the walker: table store, allocator, walk registers, results
module sv39w_datapath import sv39w_pkg::*; #(
	parameter int PAGES_IN_STORE = 64,
	parameter int LEVELS = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [PPN_W-1:0]    cfg_base,
	input  logic [1:0]          in_action,
	input  logic [PPN_W-1:0]    in_root,
	input  logic [VA_W-1:0]     in_va,
	input  logic [PPN_W-1:0]    in_target,
	input  logic [FLAGS_W-1:0]  in_flags,
	input  cmd_t                cmd,
	output sts_t                sts,
	output logic [ENTRY_W-1:0]  out_entry,
	output logic                out_found,
	output logic [STATUS_W-1:0] out_status
);

	localparam int PIDX  = (PAGES_IN_STORE > 2) ? $clog2(PAGES_IN_STORE) : 1;
	localparam int NPW   = $clog2(PAGES_IN_STORE + 1);
	localparam int LW    = (LEVELS > 2) ? $clog2(LEVELS) : 1;
	localparam int AW    = PIDX + VPN_W;
	localparam int DEPTH = PAGES_IN_STORE << VPN_W;
	localparam int VAX_W = PAGE_SHIFT + VPN_W * 4;

	logic [PPN_W-1:0]    base_q;
	logic [NPW-1:0]      next_page_q;
	logic [1:0]          action_q;
	logic [VA_W-1:0]     va_q;
	logic [PPN_W-1:0]    target_q;
	logic [FLAGS_W-1:0]  flags_q;
	logic [PPN_W-1:0]    ptr_q;
	logic [PIDX-1:0]     cur_q;
	logic [LW-1:0]       level_q;
	logic [VPN_W-1:0]    clr_cnt_q;
	logic [ENTRY_W-1:0]  rd_q;
	logic [ENTRY_W-1:0]  res_entry_q;
	logic                res_found_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [ENTRY_W-1:0]  mem [DEPTH];

	logic [VAX_W-1:0]    va_sh;
	logic [VPN_W-1:0]    vpn;
	logic [PIDX-1:0]     fresh;
	logic [PPN_W-1:0]    fresh_ppn;
	logic [PPN_W:0]      diff;
	logic [AW-1:0]       slot_addr;
	logic [AW-1:0]       wr_addr;
	logic [ENTRY_W-1:0]  wr_data;
	logic                wr_en;
	logic [ENTRY_W-1:0]  leaf_entry;
	logic [ENTRY_W-1:0]  res_entry_d;
	logic                res_found_d;
	logic [STATUS_W-1:0] res_status_d;

	// index field of the current level and the derived addresses
	assign va_sh      = VAX_W'(va_q) >> (PAGE_SHIFT + VPN_W * int'(level_q));
	assign vpn        = va_sh[VPN_W-1:0];
	assign fresh      = next_page_q[PIDX-1:0];
	assign fresh_ppn  = base_q + PPN_W'(fresh);
	assign slot_addr  = {cur_q, vpn};
	assign diff       = {1'b0, ptr_q} - {1'b0, base_q};
	assign leaf_entry = {{(ENTRY_W-PPN_W-PPN_SHIFT){1'b0}}, target_q, flags_q};

	// store write port
	always_comb begin
		wr_en   = cmd.clr_wr | cmd.link_wr | cmd.leaf_wr;
		wr_addr = slot_addr;
		wr_data = leaf_entry;
		if (cmd.clr_wr) begin
			wr_addr = {fresh, clr_cnt_q};
			wr_data = '0;
		end else if (cmd.link_wr) begin
			wr_data = {{(ENTRY_W-PPN_W-PPN_SHIFT){1'b0}}, fresh_ppn,
				{(PPN_SHIFT-1){1'b0}}, 1'b1};
		end
	end

	// table store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rd_q <= mem[slot_addr];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= PPN_W'(524288);
			next_page_q <= '0;
			clr_cnt_q   <= '0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_base;
			end
			if (cmd.bump) begin
				next_page_q <= next_page_q + NPW'(1);
			end
			if (cmd.clr_wr) begin
				clr_cnt_q <= clr_cnt_q + VPN_W'(1);
			end
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= in_action;
			va_q     <= in_va;
			target_q <= in_target;
			flags_q  <= in_flags;
			ptr_q    <= in_root;
			level_q  <= LW'(LEVELS - 1);
		end else begin
			if (cmd.ptr_from_rd) begin
				ptr_q <= rd_q[PPN_SHIFT +: PPN_W];
			end else if (cmd.link_wr) begin
				ptr_q <= fresh_ppn;
			end
			if (cmd.lvl_dec) begin
				level_q <= level_q - LW'(1);
			end
		end
		if (cmd.cur_from_ptr) begin
			cur_q <= diff[PIDX-1:0];
		end
	end

	// result selection
	always_comb begin
		res_entry_d  = '0;
		res_found_d  = 1'b0;
		res_status_d = ST_OK;
		case (cmd.res_sel)
			RES_MAP:   res_entry_d = leaf_entry;
			RES_LOOK: begin
				res_entry_d = rd_q;
				res_found_d = rd_q[0];
			end
			RES_ALLOC: res_entry_d = {{(ENTRY_W-PPN_W){1'b0}}, fresh_ppn};
			RES_FULL:  res_status_d = ST_FULL;
			RES_OUT:   res_status_d = ST_OUT;
			default:   res_entry_d = '0;
		endcase
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_entry_q  <= res_entry_d;
			res_found_q  <= res_found_d;
			res_status_q <= res_status_d;
		end
		if (cmd.out_load) begin
			out_entry  <= res_entry_q;
			out_found  <= res_found_q;
			out_status <= res_status_q;
		end
	end

	// status to the controller
	always_comb begin
		sts.action     = action_q;
		sts.ptr_ok     = !diff[PPN_W] && (diff[PPN_W-1:0] < PPN_W'(PAGES_IN_STORE));
		sts.rd_valid   = rd_q[0];
		sts.full       = (next_page_q == NPW'(PAGES_IN_STORE));
		sts.level_zero = (level_q == '0);
		sts.level_one  = (level_q == LW'(1));
		sts.clr_done   = (clr_cnt_q == {VPN_W{1'b1}});
	end

endmodule

// ===== hw/rtl/sv39w_ctrl.sv =====
// controller state machine of the walker
module sv39w_ctrl import sv39w_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISP = 4'd1;
	localparam logic [3:0] S_RD   = 4'd2;
	localparam logic [3:0] S_EVAL = 4'd3;
	localparam logic [3:0] S_CLR  = 4'd4;
	localparam logic [3:0] S_AFIN = 4'd5;
	localparam logic [3:0] S_LINK = 4'd6;
	localparam logic [3:0] S_CHK  = 4'd7;
	localparam logic [3:0] S_LEAF = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.action == ACT_ALLOC) begin
					if (sts.full) begin
						cmd.res_set = 1'b1;
						cmd.res_sel = RES_FULL;
						state_d     = S_DONE;
					end else begin
						state_d = S_CLR;
					end
				end else if (sts.action == ACT_MAP || sts.action == ACT_LOOKUP) begin
					if (!sts.ptr_ok) begin
						cmd.res_set = 1'b1;
						cmd.res_sel = RES_OUT;
						state_d     = S_DONE;
					end else begin
						cmd.cur_from_ptr = 1'b1;
						state_d          = S_RD;
					end
				end else begin
					cmd.res_set = 1'b1;
					cmd.res_sel = RES_ZERO;
					state_d     = S_DONE;
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (sts.level_zero) begin
					cmd.res_set = 1'b1;
					cmd.res_sel = RES_LOOK;
					state_d     = S_DONE;
				end else if (sts.rd_valid) begin
					cmd.ptr_from_rd = 1'b1;
					state_d         = S_CHK;
				end else if (sts.action == ACT_LOOKUP) begin
					cmd.res_set = 1'b1;
					cmd.res_sel = RES_ZERO;
					state_d     = S_DONE;
				end else if (sts.full) begin
					cmd.res_set = 1'b1;
					cmd.res_sel = RES_FULL;
					state_d     = S_DONE;
				end else begin
					state_d = S_CLR;
				end
			end
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_done) begin
					state_d = (sts.action == ACT_ALLOC) ? S_AFIN : S_LINK;
				end
			end
			S_AFIN: begin
				cmd.res_set = 1'b1;
				cmd.res_sel = RES_ALLOC;
				cmd.bump    = 1'b1;
				state_d     = S_DONE;
			end
			S_LINK: begin
				cmd.link_wr = 1'b1;
				cmd.bump    = 1'b1;
				state_d     = S_CHK;
			end
			S_CHK: begin
				if (!sts.ptr_ok) begin
					cmd.res_set = 1'b1;
					cmd.res_sel = RES_OUT;
					state_d     = S_DONE;
				end else begin
					cmd.cur_from_ptr = 1'b1;
					cmd.lvl_dec      = 1'b1;
					state_d          = sts.level_one ? S_LEAF : S_RD;
				end
			end
			S_LEAF: begin
				if (sts.action == ACT_MAP) begin
					cmd.leaf_wr = 1'b1;
					cmd.res_set = 1'b1;
					cmd.res_sel = RES_MAP;
					state_d     = S_DONE;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/sv39_page_table_map_walker_top.sv =====
// top level of the sv39 page table map walker
//
// channel  dir  handshake                  payload
// s_*      in   s_tvalid / s_tready        tuser action, tdata request fields
// m_*      out  m_tvalid / m_tready        tdata entry_value, found, status
// cfg_*    in   cfg_valid / cfg_ready      store_base_page
//
// map walks the upper table levels and writes the leaf entry; lookup ends with a read
// of the leaf entry instead. each table that map allocates, and each page that alloc
// hands out, is first cleared one entry per cycle through the single write port of the
// table store. one item is in work at a time; s_tready rises in the same cycle as m_tvalid.
// reset clears the allocator and control; store contents stay undefined until cleared.
// a result waiting in the output register holds only the final step of the next item.
module sv39_page_table_map_walker_top import sv39w_pkg::*; #(
	parameter int PAGES_IN_STORE = 64,
	parameter int LEVELS = 3
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [1:0]   s_tuser,   // action
	input  logic [143:0] s_tdata,   // root_page, virt_addr, target_page, leaf_flags
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata,   // entry_value, found, status
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [43:0]  cfg_data   // store_base_page
);

	cmd_t                cmd;
	sts_t                sts;
	logic [ENTRY_W-1:0]  out_entry;
	logic                out_found;
	logic [STATUS_W-1:0] out_status;

	assign cfg_ready = 1'b1;
	assign m_tdata   = {5'd0, out_status, out_found, out_entry};

	// controller
	sv39w_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath
	sv39w_datapath #(
		.PAGES_IN_STORE (PAGES_IN_STORE),
		.LEVELS         (LEVELS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid),
		.cfg_base   (cfg_data),
		.in_action  (s_tuser),
		.in_root    (s_tdata[43:0]),
		.in_va      (s_tdata[82:44]),
		.in_target  (s_tdata[126:83]),
		.in_flags   (s_tdata[136:127]),
		.cmd        (cmd),
		.sts        (sts),
		.out_entry  (out_entry),
		.out_found  (out_found),
		.out_status (out_status)
	);

endmodule
